FILE: src/sqvt_pkg.sv
// Shared constants, register codes and saturation helpers of the sprite quad vertex transform.
`default_nettype none

package sqvt_pkg;

    // Default fixed-point and rotation depth settings
    localparam int FRAC_BITS_DEF   = 16;
    localparam int TRIG_STAGES_DEF = 16;

    // Configuration port
    localparam int CFG_AW = 4;
    localparam logic [1:0] REG_VIEW_W = 2'd0;
    localparam logic [1:0] REG_VIEW_H = 2'd1;
    localparam logic [1:0] REG_TEX_W  = 2'd2;
    localparam logic [1:0] REG_TEX_H  = 2'd3;

    localparam logic [13:0] VIEW_W_RST = 14'd1280;
    localparam logic [13:0] VIEW_H_RST = 14'd720;
    localparam logic [13:0] TEX_W_RST  = 14'd256;
    localparam logic [13:0] TEX_H_RST  = 14'd256;

    // Pipelined divider: DIV_STEP quotient bits per stage
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = 13;
    localparam int DIV_W      = DIV_STEP * DIV_STAGES;

    // Rotation unit
    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
    localparam logic [1:0] CORNER_LAST = 2'd3;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [33:0] atan_turn(input int i);
        case (i)
            0:       return 34'sd536870912;
            1:       return 34'sd316933406;
            2:       return 34'sd167458907;
            3:       return 34'sd85004756;
            4:       return 34'sd42667331;
            5:       return 34'sd21354465;
            6:       return 34'sd10679838;
            7:       return 34'sd5340245;
            8:       return 34'sd2670163;
            9:       return 34'sd1335087;
            10:      return 34'sd667544;
            11:      return 34'sd333772;
            12:      return 34'sd166886;
            13:      return 34'sd83443;
            14:      return 34'sd41722;
            15:      return 34'sd20861;
            16:      return 34'sd10430;
            17:      return 34'sd5215;
            18:      return 34'sd2608;
            19:      return 34'sd1304;
            20:      return 34'sd652;
            21:      return 34'sd326;
            22:      return 34'sd163;
            23:      return 34'sd81;
            default: return 34'sd0;
        endcase
    endfunction

    // Clamp a product magnitude to the 48-bit range and apply its sign
    function automatic logic signed [47:0] sat_mag48(input logic [95:0] m, input logic neg);
        logic [95:0] lim;
        logic [47:0] r;
        lim = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
        r = (m > lim) ? lim[47:0] : m[47:0];
        return neg ? (~r + 48'd1) : r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (v < 64'shFFFF_8000_0000_0000) return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < 64'shFFFF_FFFF_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/sprite_quad_vertex_transform.sv
// Sprite quad vertex transform: one sprite in, four strip corners out in device space.
//
// Usage:
//   The s_ channel takes one sprite descriptor per beat. The block expands it
//   into four corner beats on the m_ channel (bottom-left, bottom-right,
//   top-left, top-right), with m_tuser carrying the corner code and m_tlast
//   marking the fourth corner. A sprite with a zero scale on either axis is
//   taken and produces no beats.
//   Throughput: one corner per cycle while the output does not stall; the
//   corner expander at the input holds a sprite for its four corners and
//   takes the next sprite with the last of them. After the expander a corner
//   passes 3 geometry stages, the rotation stages, 6 stages of rotation
//   multiply and sum, the 14-stage quotient pipeline and the output
//   register.
//   The APB port sets viewport and texture sizes; write it only while idle.
//   Reset (aresetn low, synchronous) empties the pipeline and restores the
//   default sizes. While a corner waits at the output and m_tready is low
//   the whole pipeline holds, s_tready drops with it; nothing is lost or repeated.
`default_nettype none

module sprite_quad_vertex_transform #(
    parameter int FRAC_BITS   = sqvt_pkg::FRAC_BITS_DEF,
    parameter int TRIG_STAGES = sqvt_pkg::TRIG_STAGES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // APB configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sqvt_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // Sprite stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // pos_x, pos_y, scale_x, scale_y, src_x, src_y, src_w, src_h,
    // center_x, center_y (32 each), rotation (16)
    input  wire logic [335:0]                s_tdata,
    // Corner stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // ndc_x, ndc_y, tex_u, tex_v (32 each)
    output logic      [127:0]                m_tdata,
    // corner (2)
    output logic      [1:0]                  m_tuser,
    output logic                             m_tlast
);

    localparam int TWW = (FRAC_BITS + 15 > 32) ? FRAC_BITS + 15 : 32;
    localparam int UW  = TWW + 1;
    localparam int T   = TRIG_STAGES;
    localparam int DS  = sqvt_pkg::DIV_STAGES;
    localparam int DW  = sqvt_pkg::DIV_W;
    localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [13:0] view_w_reg, view_h_reg, tex_w_reg, tex_h_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_w_reg <= sqvt_pkg::VIEW_W_RST;
            view_h_reg <= sqvt_pkg::VIEW_H_RST;
            tex_w_reg  <= sqvt_pkg::TEX_W_RST;
            tex_h_reg  <= sqvt_pkg::TEX_H_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                sqvt_pkg::REG_VIEW_W: view_w_reg <= pwdata[13:0];
                sqvt_pkg::REG_VIEW_H: view_h_reg <= pwdata[13:0];
                sqvt_pkg::REG_TEX_W:  tex_w_reg  <= pwdata[13:0];
                sqvt_pkg::REG_TEX_H:  tex_h_reg  <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sqvt_pkg::REG_VIEW_W: prdata = {18'd0, view_w_reg};
            sqvt_pkg::REG_VIEW_H: prdata = {18'd0, view_h_reg};
            sqvt_pkg::REG_TEX_W:  prdata = {18'd0, tex_w_reg};
            sqvt_pkg::REG_TEX_H:  prdata = {18'd0, tex_h_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Corner expander: hold one sprite for four beats
    logic        adv, s_accept, s_keep;
    logic        hold_valid_reg;
    logic [1:0]  cnt_reg;
    logic signed [31:0] h_pos_x_reg, h_pos_y_reg, h_scale_x_reg, h_scale_y_reg;
    logic signed [31:0] h_src_x_reg, h_src_y_reg, h_src_w_reg, h_src_h_reg;
    logic signed [31:0] h_center_x_reg, h_center_y_reg;
    logic        [15:0] h_rot_reg;
    logic               out_valid_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && (!hold_valid_reg || (cnt_reg == sqvt_pkg::CORNER_LAST));
    assign s_accept = s_tvalid && s_tready;
    assign s_keep   = (s_tdata[95:64] != 32'd0) && (s_tdata[127:96] != 32'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= 2'd0;
        end else if (s_accept) begin
            hold_valid_reg <= s_keep;
            cnt_reg        <= 2'd0;
        end else if (adv && hold_valid_reg) begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == sqvt_pkg::CORNER_LAST) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            h_pos_x_reg    <= s_tdata[31:0];
            h_pos_y_reg    <= s_tdata[63:32];
            h_scale_x_reg  <= s_tdata[95:64];
            h_scale_y_reg  <= s_tdata[127:96];
            h_src_x_reg    <= s_tdata[159:128];
            h_src_y_reg    <= s_tdata[191:160];
            h_src_w_reg    <= s_tdata[223:192];
            h_src_h_reg    <= s_tdata[255:224];
            h_center_x_reg <= s_tdata[287:256];
            h_center_y_reg <= s_tdata[319:288];
            h_rot_reg      <= s_tdata[335:320];
        end
    end

    // ------------------------------------------------------------------
    // G1: source size select, size and centre product magnitudes, texture numerators
    logic               h_ux, h_uy, h_use_tex;
    logic signed [TWW-1:0] tw_sel, th_sel;
    logic [TWW-1:0]     tw_mag, th_mag;
    logic [31:0]        sxm, sym, cxm, cym;
    logic signed [UW-1:0] u_num_next, v_num_next;

    assign h_ux      = cnt_reg[0];
    assign h_uy      = !cnt_reg[1];
    assign h_use_tex = (h_src_w_reg <= 32'sd0) || (h_src_h_reg <= 32'sd0);
    assign tw_sel    = h_use_tex ? $signed(TWW'(tex_w_reg) << FRAC_BITS)
                                 : $signed(TWW'(h_src_w_reg));
    assign th_sel    = h_use_tex ? $signed(TWW'(tex_h_reg) << FRAC_BITS)
                                 : $signed(TWW'(h_src_h_reg));
    assign tw_mag    = tw_sel[TWW-1] ? (~tw_sel + 1'b1) : tw_sel;
    assign th_mag    = th_sel[TWW-1] ? (~th_sel + 1'b1) : th_sel;
    assign sxm       = h_scale_x_reg[31] ? (~h_scale_x_reg + 1'b1) : h_scale_x_reg;
    assign sym       = h_scale_y_reg[31] ? (~h_scale_y_reg + 1'b1) : h_scale_y_reg;
    assign cxm       = h_center_x_reg[31] ? (~h_center_x_reg + 1'b1) : h_center_x_reg;
    assign cym       = h_center_y_reg[31] ? (~h_center_y_reg + 1'b1) : h_center_y_reg;
    assign u_num_next = UW'(h_src_x_reg) + (h_ux ? UW'(tw_sel) : UW'(0));
    assign v_num_next = UW'(h_src_y_reg) + (h_uy ? UW'(th_sel) : UW'(0));

    logic                 g1_valid_reg;
    logic [1:0]           g1_corner_reg;
    logic [TWW+31:0]      g1_pdw_reg, g1_pdh_reg;
    logic [63:0]          g1_pmx_reg, g1_pmy_reg;
    logic                 g1_ndw_reg, g1_ndh_reg, g1_nmx_reg, g1_nmy_reg;
    logic signed [31:0]   g1_pos_x_reg, g1_pos_y_reg;
    logic [15:0]          g1_rot_reg;
    logic signed [UW-1:0] g1_u_reg, g1_v_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_corner_reg <= cnt_reg;
            g1_pdw_reg    <= (TWW+32)'(tw_mag) * (TWW+32)'(sxm);
            g1_pdh_reg    <= (TWW+32)'(th_mag) * (TWW+32)'(sym);
            g1_pmx_reg    <= 64'(sxm) * 64'(cxm);
            g1_pmy_reg    <= 64'(sym) * 64'(cym);
            g1_ndw_reg    <= tw_sel[TWW-1] ^ h_scale_x_reg[31];
            g1_ndh_reg    <= th_sel[TWW-1] ^ h_scale_y_reg[31];
            g1_nmx_reg    <= h_scale_x_reg[31] ^ h_center_x_reg[31];
            g1_nmy_reg    <= h_scale_y_reg[31] ^ h_center_y_reg[31];
            g1_pos_x_reg  <= h_pos_x_reg;
            g1_pos_y_reg  <= h_pos_y_reg;
            g1_rot_reg    <= h_rot_reg;
            g1_u_reg      <= u_num_next;
            g1_v_reg      <= v_num_next;
        end
    end

    // ------------------------------------------------------------------
    // G2: scale down and clamp the products
    logic                 g2_valid_reg;
    logic [1:0]           g2_corner_reg;
    logic signed [47:0]   g2_dw_reg, g2_dh_reg, g2_mx_reg, g2_my_reg;
    logic signed [31:0]   g2_pos_x_reg, g2_pos_y_reg;
    logic [15:0]          g2_rot_reg;
    logic signed [UW-1:0] g2_u_reg, g2_v_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            g2_corner_reg <= g1_corner_reg;
            g2_dw_reg     <= sqvt_pkg::sat_mag48(96'(g1_pdw_reg >> FRAC_BITS), g1_ndw_reg);
            g2_dh_reg     <= sqvt_pkg::sat_mag48(96'(g1_pdh_reg >> FRAC_BITS), g1_ndh_reg);
            g2_mx_reg     <= sqvt_pkg::sat_mag48(96'(g1_pmx_reg >> FRAC_BITS), g1_nmx_reg);
            g2_my_reg     <= sqvt_pkg::sat_mag48(96'(g1_pmy_reg >> FRAC_BITS), g1_nmy_reg);
            g2_pos_x_reg  <= g1_pos_x_reg;
            g2_pos_y_reg  <= g1_pos_y_reg;
            g2_rot_reg    <= g1_rot_reg;
            g2_u_reg      <= g1_u_reg;
            g2_v_reg      <= g1_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // G3 and rotation stages: corner offset, quarter turn split, CORDIC
    logic signed [63:0] px_wide, py_wide;
    logic [16:0]        rot_sum;
    logic [1:0]         quad_next;
    logic signed [15:0] res_angle;

    assign px_wide   = (g2_corner_reg[0] ? 64'(g2_dw_reg) : 64'sd0) - 64'(g2_mx_reg);
    assign py_wide   = (!g2_corner_reg[1] ? 64'(g2_dh_reg) : 64'sd0) - 64'(g2_my_reg);
    assign rot_sum   = {1'b0, g2_rot_reg} + 17'h2000;
    assign quad_next = rot_sum[15:14];
    assign res_angle = g2_rot_reg - {quad_next, 14'd0};

    logic                 cv_reg     [0:T];
    logic signed [33:0]   cx_reg     [0:T];
    logic signed [33:0]   cy_reg     [0:T];
    logic signed [33:0]   cz_reg     [0:T];
    logic signed [33:0]   cx_next    [0:T];
    logic signed [33:0]   cy_next    [0:T];
    logic signed [33:0]   cz_next    [0:T];
    logic [1:0]           cq_reg     [0:T];
    logic [1:0]           ccorner_reg[0:T];
    logic signed [47:0]   cpx_reg    [0:T];
    logic signed [47:0]   cpy_reg    [0:T];
    logic signed [31:0]   cposx_reg  [0:T];
    logic signed [31:0]   cposy_reg  [0:T];
    logic signed [UW-1:0] cu_reg     [0:T];
    logic signed [UW-1:0] cvn_reg    [0:T];

    // One micro-rotation per stage toward zero residual angle
    always_comb begin
        cx_next[0] = sqvt_pkg::INV_GAIN;
        cy_next[0] = 34'sd0;
        cz_next[0] = {{2{res_angle[15]}}, res_angle, 16'd0};
        for (int i = 0; i < T; i++) begin
            if (cz_reg[i] >= 34'sd0) begin
                cx_next[i+1] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] + (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] - sqvt_pkg::atan_turn(i);
            end else begin
                cx_next[i+1] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] - (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] + sqvt_pkg::atan_turn(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i <= T; i++) begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            cq_reg[0]      <= quad_next;
            ccorner_reg[0] <= g2_corner_reg;
            cpx_reg[0]     <= sqvt_pkg::sat48(px_wide);
            cpy_reg[0]     <= sqvt_pkg::sat48(py_wide);
            cposx_reg[0]   <= g2_pos_x_reg;
            cposy_reg[0]   <= g2_pos_y_reg;
            cu_reg[0]      <= g2_u_reg;
            cvn_reg[0]     <= g2_v_reg;
            for (int i = 0; i < T; i++) begin
                cq_reg[i+1]      <= cq_reg[i];
                ccorner_reg[i+1] <= ccorner_reg[i];
                cpx_reg[i+1]     <= cpx_reg[i];
                cpy_reg[i+1]     <= cpy_reg[i];
                cposx_reg[i+1]   <= cposx_reg[i];
                cposy_reg[i+1]   <= cposy_reg[i];
                cu_reg[i+1]      <= cu_reg[i];
                cvn_reg[i+1]     <= cvn_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // R0: quarter turn, sign and magnitude of operands
    logic [33:0] ax, ay;
    logic [47:0] pxm, pym;
    logic [31:0] cm_next, sm_next;
    logic        cn_next, sn_next;

    assign ax  = cx_reg[T][33] ? (~cx_reg[T] + 1'b1) : cx_reg[T];
    assign ay  = cy_reg[T][33] ? (~cy_reg[T] + 1'b1) : cy_reg[T];
    assign pxm = cpx_reg[T][47] ? (~cpx_reg[T] + 1'b1) : cpx_reg[T];
    assign pym = cpy_reg[T][47] ? (~cpy_reg[T] + 1'b1) : cpy_reg[T];

    always_comb begin
        case (cq_reg[T])
            2'd0: begin
                cm_next = ax[31:0]; cn_next = cx_reg[T][33];
                sm_next = ay[31:0]; sn_next = cy_reg[T][33];
            end
            2'd1: begin
                cm_next = ay[31:0]; cn_next = !cy_reg[T][33];
                sm_next = ax[31:0]; sn_next = cx_reg[T][33];
            end
            2'd2: begin
                cm_next = ax[31:0]; cn_next = !cx_reg[T][33];
                sm_next = ay[31:0]; sn_next = !cy_reg[T][33];
            end
            default: begin
                cm_next = ay[31:0]; cn_next = cy_reg[T][33];
                sm_next = ax[31:0]; sn_next = !cx_reg[T][33];
            end
        endcase
    end

    logic                 r0_valid_reg;
    logic [1:0]           r0_corner_reg;
    logic [47:0]          r0_pxm_reg, r0_pym_reg;
    logic                 r0_pxn_reg, r0_pyn_reg;
    logic [31:0]          r0_cm_reg, r0_sm_reg;
    logic                 r0_cn_reg, r0_sn_reg;
    logic signed [31:0]   r0_posx_reg, r0_posy_reg;
    logic signed [UW-1:0] r0_u_reg, r0_v_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            r0_corner_reg <= ccorner_reg[T];
            r0_pxm_reg    <= pxm;
            r0_pym_reg    <= pym;
            r0_pxn_reg    <= cpx_reg[T][47];
            r0_pyn_reg    <= cpy_reg[T][47];
            r0_cm_reg     <= cm_next;
            r0_sm_reg     <= sm_next;
            r0_cn_reg     <= cn_next;
            r0_sn_reg     <= sn_next;
            r0_posx_reg   <= cposx_reg[T];
            r0_posy_reg   <= cposy_reg[T];
            r0_u_reg      <= cu_reg[T];
            r0_v_reg      <= cvn_reg[T];
        end
    end

    // ------------------------------------------------------------------
    // R1: partial products px*c, py*s, px*s, py*c (low and high halves)
    logic [47:0] am [0:3];
    logic [31:0] bm [0:3];
    logic        pn [0:3];

    always_comb begin
        am[0] = r0_pxm_reg; bm[0] = r0_cm_reg; pn[0] = r0_pxn_reg ^ r0_cn_reg;
        am[1] = r0_pym_reg; bm[1] = r0_sm_reg; pn[1] = r0_pyn_reg ^ r0_sn_reg;
        am[2] = r0_pxm_reg; bm[2] = r0_sm_reg; pn[2] = r0_pxn_reg ^ r0_sn_reg;
        am[3] = r0_pym_reg; bm[3] = r0_cm_reg; pn[3] = r0_pyn_reg ^ r0_cn_reg;
    end

    logic                 r1_valid_reg;
    logic [1:0]           r1_corner_reg;
    logic [63:0]          r1_lo_reg  [0:3];
    logic [47:0]          r1_hi_reg  [0:3];
    logic                 r1_neg_reg [0:3];
    logic signed [31:0]   r1_posx_reg, r1_posy_reg;
    logic signed [UW-1:0] r1_u_reg, r1_v_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r1_lo_reg[k]  <= 64'(am[k][31:0]) * 64'(bm[k]);
                r1_hi_reg[k]  <= 48'(am[k][47:32]) * 48'(bm[k]);
                r1_neg_reg[k] <= pn[k];
            end
            r1_corner_reg <= r0_corner_reg;
            r1_posx_reg   <= r0_posx_reg;
            r1_posy_reg   <= r0_posy_reg;
            r1_u_reg      <= r0_u_reg;
            r1_v_reg      <= r0_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // R2: join the partial products
    logic                 r2_valid_reg;
    logic [1:0]           r2_corner_reg;
    logic [79:0]          r2_sum_reg [0:3];
    logic                 r2_neg_reg [0:3];
    logic signed [31:0]   r2_posx_reg, r2_posy_reg;
    logic signed [UW-1:0] r2_u_reg, r2_v_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r2_sum_reg[k] <= (80'(r1_hi_reg[k]) << 32) + 80'(r1_lo_reg[k]);
                r2_neg_reg[k] <= r1_neg_reg[k];
            end
            r2_corner_reg <= r1_corner_reg;
            r2_posx_reg   <= r1_posx_reg;
            r2_posy_reg   <= r1_posy_reg;
            r2_u_reg      <= r1_u_reg;
            r2_v_reg      <= r1_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // R3: drop the Q1.30 fraction and clamp
    logic                 r3_valid_reg;
    logic [1:0]           r3_corner_reg;
    logic signed [47:0]   r3_m_reg [0:3];
    logic signed [31:0]   r3_posx_reg, r3_posy_reg;
    logic signed [UW-1:0] r3_u_reg, r3_v_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r3_m_reg[k] <= sqvt_pkg::sat_mag48(96'(r2_sum_reg[k] >> 30), r2_neg_reg[k]);
            end
            r3_corner_reg <= r2_corner_reg;
            r3_posx_reg   <= r2_posx_reg;
            r3_posy_reg   <= r2_posy_reg;
            r3_u_reg      <= r2_u_reg;
            r3_v_reg      <= r2_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // R4: rotated offset; R5: add the position
    logic                 r4_valid_reg;
    logic [1:0]           r4_corner_reg;
    logic signed [47:0]   r4_rx_reg, r4_ry_reg;
    logic signed [31:0]   r4_posx_reg, r4_posy_reg;
    logic signed [UW-1:0] r4_u_reg, r4_v_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            r4_rx_reg     <= sqvt_pkg::sat48(64'(r3_m_reg[0]) - 64'(r3_m_reg[1]));
            r4_ry_reg     <= sqvt_pkg::sat48(64'(r3_m_reg[2]) + 64'(r3_m_reg[3]));
            r4_corner_reg <= r3_corner_reg;
            r4_posx_reg   <= r3_posx_reg;
            r4_posy_reg   <= r3_posy_reg;
            r4_u_reg      <= r3_u_reg;
            r4_v_reg      <= r3_v_reg;
        end
    end

    logic                 r5_valid_reg;
    logic [1:0]           r5_corner_reg;
    logic signed [47:0]   r5_x_reg, r5_y_reg;
    logic signed [UW-1:0] r5_u_reg, r5_v_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            r5_x_reg      <= sqvt_pkg::sat48(64'(r4_rx_reg) + 64'(r4_posx_reg));
            r5_y_reg      <= sqvt_pkg::sat48(64'(r4_ry_reg) + 64'(r4_posy_reg));
            r5_corner_reg <= r4_corner_reg;
            r5_u_reg      <= r4_u_reg;
            r5_v_reg      <= r4_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Quotient pipeline: sign-magnitude restoring division, four lanes
    logic signed [48:0] x2, y2;
    logic [48:0]        x2m, y2m;
    logic [UW-1:0]      um, vm;
    logic [13:0]        dsor [0:3];

    assign x2  = {r5_x_reg, 1'b0};
    assign y2  = {r5_y_reg, 1'b0};
    assign x2m = x2[48] ? (~x2 + 1'b1) : x2;
    assign y2m = y2[48] ? (~y2 + 1'b1) : y2;
    assign um  = r5_u_reg[UW-1] ? (~r5_u_reg + 1'b1) : r5_u_reg;
    assign vm  = r5_v_reg[UW-1] ? (~r5_v_reg + 1'b1) : r5_v_reg;

    // A zero register divides as one
    assign dsor[0] = (view_w_reg == 14'd0) ? 14'd1 : view_w_reg;
    assign dsor[1] = (view_h_reg == 14'd0) ? 14'd1 : view_h_reg;
    assign dsor[2] = (tex_w_reg == 14'd0) ? 14'd1 : tex_w_reg;
    assign dsor[3] = (tex_h_reg == 14'd0) ? 14'd1 : tex_h_reg;

    logic          dvalid_reg  [0:DS];
    logic [1:0]    dcorner_reg [0:DS];
    logic [3:0]    dneg_reg    [0:DS];
    logic [DW-1:0] dwd_reg     [0:DS][0:3];
    logic [13:0]   drem_reg    [0:DS][0:3];
    logic [DW-1:0] dwd_next    [0:DS][0:3];
    logic [13:0]   drem_next   [0:DS][0:3];

    // Shift dividend out at the top, quotient bits in at the bottom
    always_comb begin
        logic [DW-1:0] w;
        logic [13:0]   r;
        logic [14:0]   t;
        dwd_next[0][0] = DW'(x2m);
        dwd_next[0][1] = DW'(y2m);
        dwd_next[0][2] = DW'(um);
        dwd_next[0][3] = DW'(vm);
        for (int ch = 0; ch < 4; ch++) begin
            drem_next[0][ch] = 14'd0;
        end
        for (int j = 0; j < DS; j++) begin
            for (int ch = 0; ch < 4; ch++) begin
                w = dwd_reg[j][ch];
                r = drem_reg[j][ch];
                for (int st = 0; st < sqvt_pkg::DIV_STEP; st++) begin
                    t = {r, w[DW-1]};
                    if (t >= {1'b0, dsor[ch]}) begin
                        r = 14'(t - {1'b0, dsor[ch]});
                        w = {w[DW-2:0], 1'b1};
                    end else begin
                        r = t[13:0];
                        w = {w[DW-2:0], 1'b0};
                    end
                end
                dwd_next[j+1][ch]  = w;
                drem_next[j+1][ch] = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j <= DS; j++) begin
                for (int ch = 0; ch < 4; ch++) begin
                    dwd_reg[j][ch]  <= dwd_next[j][ch];
                    drem_reg[j][ch] <= drem_next[j][ch];
                end
            end
            dcorner_reg[0] <= r5_corner_reg;
            dneg_reg[0]    <= {r5_v_reg[UW-1], r5_u_reg[UW-1], r5_y_reg[47], r5_x_reg[47]};
            for (int j = 0; j < DS; j++) begin
                dcorner_reg[j+1] <= dcorner_reg[j];
                dneg_reg[j+1]    <= dneg_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply signs, offset the NDC lanes by one, clamp to 32 bits
    logic signed [63:0] qs [0:3];
    logic [1:0]         out_corner_reg;
    logic signed [31:0] out_nx_reg, out_ny_reg, out_u_reg, out_v_reg;

    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            qs[ch] = dneg_reg[DS][ch] ? -$signed(64'(dwd_reg[DS][ch]))
                                      : $signed(64'(dwd_reg[DS][ch]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_corner_reg <= dcorner_reg[DS];
            out_nx_reg     <= sqvt_pkg::sat32(qs[0] - ONE64);
            out_ny_reg     <= sqvt_pkg::sat32(ONE64 - qs[1]);
            out_u_reg      <= sqvt_pkg::sat32(qs[2]);
            out_v_reg      <= sqvt_pkg::sat32(qs[3]);
        end
    end

    // ------------------------------------------------------------------
    // Valid bits: advance with the pipeline, clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_valid_reg  <= 1'b0;
            g2_valid_reg  <= 1'b0;
            r0_valid_reg  <= 1'b0;
            r1_valid_reg  <= 1'b0;
            r2_valid_reg  <= 1'b0;
            r3_valid_reg  <= 1'b0;
            r4_valid_reg  <= 1'b0;
            r5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= T; i++) begin
                cv_reg[i] <= 1'b0;
            end
            for (int j = 0; j <= DS; j++) begin
                dvalid_reg[j] <= 1'b0;
            end
        end else if (adv) begin
            g1_valid_reg <= hold_valid_reg;
            g2_valid_reg <= g1_valid_reg;
            cv_reg[0]    <= g2_valid_reg;
            for (int i = 0; i < T; i++) begin
                cv_reg[i+1] <= cv_reg[i];
            end
            r0_valid_reg  <= cv_reg[T];
            r1_valid_reg  <= r0_valid_reg;
            r2_valid_reg  <= r1_valid_reg;
            r3_valid_reg  <= r2_valid_reg;
            r4_valid_reg  <= r3_valid_reg;
            r5_valid_reg  <= r4_valid_reg;
            dvalid_reg[0] <= r5_valid_reg;
            for (int j = 0; j < DS; j++) begin
                dvalid_reg[j+1] <= dvalid_reg[j];
            end
            out_valid_reg <= dvalid_reg[DS];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_v_reg, out_u_reg, out_ny_reg, out_nx_reg};
    assign m_tuser  = out_corner_reg;
    assign m_tlast  = (out_corner_reg == sqvt_pkg::CORNER_LAST);

endmodule

`default_nettype wire

FILE: dv/sprite_quad_vertex_transform_chk.sv
// Checker for the sprite quad vertex transform: predicts corner beats and compares them.
`timescale 1ns / 1ps

module sprite_quad_vertex_transform_chk (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic                        pready,
    input  wire logic [sqvt_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic [335:0]                s_tdata,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [127:0]                m_tdata,
    input  wire logic [1:0]                  m_tuser,
    input  wire logic                        m_tlast,
    output int                               corners_pending,
    output int                               errors
);

    localparam int  FB  = sqvt_pkg::FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << FB;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [31:0] ndc_x;
        logic signed [31:0] ndc_y;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic               last;
    } corner_t;

    corner_t     corner_q[$];
    logic [13:0] view_w, view_h, tex_w, tex_h;

    assign corners_pending = corner_q.size();

    function automatic longint clamp48(longint v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    // exact a*b >> sh, truncated toward zero, clamped to 48 bits
    function automatic longint mul_shift(longint a, longint b, int sh);
        logic         neg;
        logic [127:0] ua, ub, m, lim;
        neg = (a < 0) != (b < 0);
        ua  = {64'd0, 64'(a < 0 ? -a : a)};
        ub  = {64'd0, 64'(b < 0 ? -b : b)};
        m   = (ua * ub) >> sh;
        lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint arctan_step(int i);
        case (i)
            0: return 536870912;   1: return 316933406;  2: return 167458907;
            3: return 85004756;    4: return 42667331;   5: return 21354465;
            6: return 10679838;    7: return 5340245;    8: return 2670163;
            9: return 1335087;     10: return 667544;    11: return 333772;
            12: return 166886;     13: return 83443;     14: return 41722;
            15: return 20861;      16: return 10430;     17: return 5215;
            18: return 2608;       19: return 1304;      20: return 652;
            21: return 326;        22: return 163;       default: return 81;
        endcase
    endfunction

    // quarter-turn fold, then CORDIC on the residual angle
    task automatic cordic_sincos(input logic [15:0] angle, output longint c, output longint s);
        int     q;
        longint res, x, y, z, nx;
        q   = ((int'(angle) + 'h2000) >> 14) & 3;
        res = longint'((int'(angle) - q * 'h4000) & 'hFFFF);
        if (res >= 'h8000) res -= 'h10000;
        z = res * 65536;
        x = longint'(sqvt_pkg::INV_GAIN);
        y = 0;
        for (int i = 0; i < sqvt_pkg::TRIG_STAGES_DEF && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - arctan_step(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + arctan_step(i);
            end
            x = nx;
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // expand one sprite into its four expected corners
    task automatic predict_corners(input logic [335:0] d);
        longint pos_x, pos_y, scl_x, scl_y, src_x, src_y, tw, th, cen_x, cen_y;
        longint vw, vh, tdw, tdh, c, s, dw, dh, mx, my, px, py, rx, ry, x, y;
        corner_t e;
        pos_x = longint'($signed(d[31:0]));    pos_y = longint'($signed(d[63:32]));
        scl_x = longint'($signed(d[95:64]));   scl_y = longint'($signed(d[127:96]));
        src_x = longint'($signed(d[159:128])); src_y = longint'($signed(d[191:160]));
        tw    = longint'($signed(d[223:192])); th    = longint'($signed(d[255:224]));
        cen_x = longint'($signed(d[287:256])); cen_y = longint'($signed(d[319:288]));
        vw  = view_w == 0 ? 1 : longint'(view_w);
        vh  = view_h == 0 ? 1 : longint'(view_h);
        tdw = tex_w == 0 ? 1 : longint'(tex_w);
        tdh = tex_h == 0 ? 1 : longint'(tex_h);
        if (scl_x == 0 || scl_y == 0) return;
        if (tw <= 0 || th <= 0) begin
            tw = longint'(tex_w) * ONE;
            th = longint'(tex_h) * ONE;
        end
        cordic_sincos(d[335:320], c, s);
        dw = mul_shift(tw, scl_x, FB);
        dh = mul_shift(th, scl_y, FB);
        mx = mul_shift(scl_x, cen_x, FB);
        my = mul_shift(scl_y, cen_y, FB);
        for (int k = 0; k < 4; k++) begin
            px = clamp48((k[0] ? dw : 0) - mx);
            py = clamp48((k < 2 ? dh : 0) - my);
            rx = clamp48(mul_shift(px, c, 30) - mul_shift(py, s, 30));
            ry = clamp48(mul_shift(px, s, 30) + mul_shift(py, c, 30));
            x  = clamp48(rx + pos_x);
            y  = clamp48(ry + pos_y);
            e.corner = k[1:0];
            e.ndc_x  = clamp32((2 * x) / vw - ONE);
            e.ndc_y  = clamp32(ONE - (2 * y) / vh);
            e.tex_u  = clamp32((src_x + (k[0] ? tw : 0)) / tdw);
            e.tex_v  = clamp32((src_y + (k < 2 ? th : 0)) / tdh);
            e.last   = (k == 3);
            corner_q.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    // track register writes, predict on sprite beats, compare corner beats
    always @(posedge aclk) begin
        corner_t e;
        if (!aresetn) begin
            view_w = sqvt_pkg::VIEW_W_RST; view_h = sqvt_pkg::VIEW_H_RST;
            tex_w  = sqvt_pkg::TEX_W_RST;  tex_h  = sqvt_pkg::TEX_H_RST;
            corner_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    sqvt_pkg::REG_VIEW_W: view_w = pwdata[13:0];
                    sqvt_pkg::REG_VIEW_H: view_h = pwdata[13:0];
                    sqvt_pkg::REG_TEX_W:  tex_w  = pwdata[13:0];
                    default:              tex_h  = pwdata[13:0];
                endcase
            end
            if (s_tvalid && s_tready) predict_corners(s_tdata);
            if (m_tvalid && m_tready) begin
                if (corner_q.size() == 0) begin
                    report_mismatch("unexpected corner beat", longint'(m_tuser), 0);
                end else begin
                    e = corner_q.pop_front();
                    if (m_tuser != e.corner) report_mismatch("corner", m_tuser, e.corner);
                    if (m_tlast != e.last) report_mismatch("last", m_tlast, e.last);
                    if (m_tdata[31:0] != e.ndc_x)
                        report_mismatch("ndc_x", m_tdata[31:0], e.ndc_x);
                    if (m_tdata[63:32] != e.ndc_y)
                        report_mismatch("ndc_y", m_tdata[63:32], e.ndc_y);
                    if (m_tdata[95:64] != e.tex_u)
                        report_mismatch("tex_u", m_tdata[95:64], e.tex_u);
                    if (m_tdata[127:96] != e.tex_v)
                        report_mismatch("tex_v", m_tdata[127:96], e.tex_v);
                end
            end
        end
    end

endmodule

FILE: dv/sprite_quad_vertex_transform_tb.sv
// Testbench top for the sprite quad vertex transform: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module sprite_quad_vertex_transform_tb;

    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 300000;

    logic                        aclk, aresetn;
    logic                        psel, penable, pwrite, pready;
    logic [sqvt_pkg::CFG_AW-1:0] paddr;
    logic [31:0]                 pwdata, prdata;
    logic                        s_tvalid, s_tready;
    logic [335:0]                s_tdata;    // pos_x..center_y (32 each), rotation (16)
    logic                        m_tvalid, m_tready;
    logic [127:0]                m_tdata;    // ndc_x, ndc_y, tex_u, tex_v (32 each)
    logic [1:0]                  m_tuser;    // corner
    logic                        m_tlast;
    int                          corners_pending, errors, cycles, sprites_sent;
    int                          send_idle_pct, recv_idle_pct;

    sprite_quad_vertex_transform u_top (.*);

    sprite_quad_vertex_transform_chk u_chk (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // receiver stall pattern
    initial m_tready = 0;
    always @(negedge aclk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // bound the run
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sprite_quad_vertex_transform_tb failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel = 1; pwrite = 1; penable = 0;
        paddr = sqvt_pkg::CFG_AW'(idx) << 2; pwdata = val;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // idle mode follows how far the run has come
    task automatic send_sprite(input int f[10], input logic [15:0] rot);
        if (sprites_sent < 75) begin
            send_idle_pct = 33; recv_idle_pct = 75;
        end else if (sprites_sent < 150) begin
            send_idle_pct = 75; recv_idle_pct = 33;
        end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tdata = {rot, f[9], f[8], f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sprites_sent++;
    endtask

    function automatic int spread(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // mostly plausible sprites, some raw bit noise and some zero scales
    task automatic send_random_sprite();
        int f[10];
        if ($urandom_range(0, 4) == 0) begin
            foreach (f[i]) f[i] = $urandom;
        end else begin
            f[0] = spread(2048 << 16); f[1] = spread(2048 << 16);
            f[2] = spread(4 << 16);    f[3] = spread(4 << 16);
            f[4] = spread(512 << 16);  f[5] = spread(512 << 16);
            f[6] = int'($urandom_range(0, 300 << 16)) - (20 << 16);
            f[7] = int'($urandom_range(0, 300 << 16)) - (20 << 16);
            f[8] = spread(64 << 16);   f[9] = spread(64 << 16);
        end
        if ($urandom_range(0, 19) == 0) f[2 + $urandom_range(0, 1)] = 0;
        send_sprite(f, 16'($urandom));
    endtask

    task automatic drain();
        s_tvalid = 0;
        while (corners_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_sizes(input logic [13:0] vw, vh, tw, th);
        reg_write(sqvt_pkg::REG_VIEW_W, 32'(vw));
        reg_write(sqvt_pkg::REG_VIEW_H, 32'(vh));
        reg_write(sqvt_pkg::REG_TEX_W, 32'(tw));
        reg_write(sqvt_pkg::REG_TEX_H, 32'(th));
    endtask

    initial begin
        int unit[10];
        int f[10];
        logic [15:0] angles[6];
        aresetn = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = 0; sprites_sent = 0;
        send_idle_pct = 33; recv_idle_pct = 75;
        unit = '{100 << 16, 50 << 16, 1 << 16, 1 << 16, 0, 0, 32 << 16, 16 << 16,
                 8 << 16, 4 << 16};
        angles = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000, 16'h8000, 16'hFFFF};
        repeat (4) @(negedge aclk);
        aresetn = 1;

        set_sizes(sqvt_pkg::VIEW_W_RST, sqvt_pkg::VIEW_H_RST,
                  sqvt_pkg::TEX_W_RST, sqvt_pkg::TEX_H_RST);
        // directed: every quadrant fold, zero scales, default source, extremes
        foreach (angles[i]) send_sprite(unit, angles[i]);
        f = unit; f[2] = 0;  send_sprite(f, 16'h0100);
        f = unit; f[3] = 0;  send_sprite(f, 16'h0100);
        f = unit; f[6] = 0;  send_sprite(f, 16'h0000);
        f = unit; f[7] = -5; send_sprite(f, 16'h3000);
        foreach (f[i]) f[i] = 32'h7FFF_FFFF;
        send_sprite(f, 16'hFFFF);
        foreach (f[i]) f[i] = 32'h8000_0000;
        send_sprite(f, 16'h8000);
        foreach (f[i]) f[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        send_sprite(f, 16'h5555);
        foreach (f[i]) f[i] = -1;
        send_sprite(f, 16'hAAAA);
        repeat (30) send_random_sprite();
        drain();

        set_sizes(14'd1, 14'd1, 14'd1, 14'd1);
        repeat (45) send_random_sprite();
        drain();

        set_sizes(14'd8192, 14'd8192, 14'd8192, 14'd8192);
        repeat (45) send_random_sprite();
        drain();

        // zero registers act as divisor one but give a zero default size
        set_sizes(14'd0, 14'd0, 14'd0, 14'd0);
        repeat (40) send_random_sprite();
        drain();

        set_sizes(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                  14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
        repeat (45) send_random_sprite();
        drain();

        if (errors == 0)
            $display("sprite_quad_vertex_transform_tb passed");
        else
            $display("sprite_quad_vertex_transform_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/sqvt_pkg.sv
src/sprite_quad_vertex_transform.sv
dv/sprite_quad_vertex_transform_chk.sv
dv/sprite_quad_vertex_transform_tb.sv
